// File: hw/rtl/stq_pkg.sv
// shared types and constants of the sorted timer queue
package stq_pkg;

  // fixed widths of the channel fields
  localparam int unsigned OPCODE_W    = 2;
  localparam int unsigned ID_W        = 8;
  localparam int unsigned EXP_W       = 32;
  localparam int unsigned STATUS_W    = 3;

  // most expired beats one tick may give
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned NRES_W      = $clog2(MAX_RESULTS + 1);

  typedef enum logic [OPCODE_W-1:0] {
    OP_ADD    = 2'd0,
    OP_ADJUST = 2'd1,
    OP_DELETE = 2'd2,
    OP_TICK   = 2'd3
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK          = 3'd0,
    STS_EXPIRED     = 3'd1,
    STS_FULL        = 3'd2,
    STS_NOT_FOUND   = 3'd3,
    STS_NOTHING_DUE = 3'd4,
    STS_DUPLICATE   = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND_RD,
    ST_FIND_CMP,
    ST_RM_RD,
    ST_RM_WR,
    ST_INS_RD,
    ST_INS_CMP,
    ST_TICK_RD,
    ST_TICK_CMP
  } state_e;

  // flags from the shared compare unit
  typedef struct packed {
    logic hit;  // stored handle equals the key id
    logic due;  // stored expiry at or below the key time
  } cmp_res_t;

endpackage

// File: hw/rtl/stq_in_if.sv
// command channel of the sorted timer queue
interface stq_in_if import stq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [ID_W-1:0]     timer_id;
  logic [EXP_W-1:0]    expire_time;
  logic [EXP_W-1:0]    now_time;

  modport source (output valid, opcode, timer_id, expire_time, now_time, input ready);
  modport sink   (input valid, opcode, timer_id, expire_time, now_time, output ready);
endinterface

// File: hw/rtl/stq_out_if.sv
// result channel of the sorted timer queue
interface stq_out_if import stq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ID_W-1:0]     out_timer_id;
  logic [EXP_W-1:0]    out_expire_time;
  logic                last;

  modport source (output valid, status, out_timer_id, out_expire_time, last, input ready);
  modport sink   (input valid, status, out_timer_id, out_expire_time, last, output ready);
endinterface

// File: hw/rtl/stq_mem.sv
// timer entry store: one write port, one read port with registered data
module stq_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 40,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/stq_cmp.sv
// shared compare unit: id match and expiry order against the held key
module stq_cmp import stq_pkg::*; #(
  parameter int unsigned TIME_BITS = 32,
  parameter int unsigned ID_BITS   = 8
) (
  input  logic [TIME_BITS-1:0] ent_exp_i,
  input  logic [ID_BITS-1:0]   ent_id_i,
  input  logic [TIME_BITS-1:0] key_time_i,
  input  logic [ID_BITS-1:0]   key_id_i,
  output cmp_res_t             res_o
);

  always_comb begin
    res_o.hit = (ent_id_i == key_id_i);
    res_o.due = (ent_exp_i <= key_time_i);
  end

endmodule

// File: hw/rtl/sorted_timer_queue.sv
// sorted timer queue: top level with the operation sequencer
//
//   channel | dir | payload                                          | beat when
//   in_i    | in  | opcode, timer_id, expire_time, now_time          | valid && ready
//   out_o   | out | status, out_timer_id, out_expire_time, last      | valid && ready
//
// one compare unit and a one-read one-write memory, a read state and then a compare
// or write state per entry visited: lookup walks from the head, removal and insertion
// move one entry per visit; a tick removes each due timer from the head like a delete
// reset empties the queue at once; memory contents are never cleared
// in_i is ready only between items; a stalled out_o holds the sequencer at its
// next result while the output register waits
module sorted_timer_queue import stq_pkg::*; #(
  parameter int unsigned CAPACITY  = 16,
  parameter int unsigned TIME_BITS = 32,
  parameter int unsigned ID_BITS   = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  stq_in_if.sink    in_i,
  stq_out_if.source out_o
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned ENT_W = TIME_BITS + ID_BITS;

  state_e               state_q, state_d;
  opcode_e              op_q;
  logic [ID_BITS-1:0]   id_q;
  logic [TIME_BITS-1:0] key_q;
  logic [CNT_W-1:0]     idx_q, idx_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [NRES_W-1:0]    nres_q, nres_d;
  logic                 pend_q, pend_d;
  logic [ID_BITS-1:0]   hold_id_q, hold_id_d;
  logic [TIME_BITS-1:0] hold_exp_q, hold_exp_d;

  logic [CNT_W-1:0]     idx_inc, idx_dec, cnt_inc, cnt_dec;

  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr, mem_raddr;
  logic [ENT_W-1:0]     mem_wdata, mem_rdata;
  logic [TIME_BITS-1:0] rd_exp;
  logic [ID_BITS-1:0]   rd_id;
  cmp_res_t             cmp;

  logic                 in_beat, slot_free;
  logic                 emit;
  status_e              e_status;
  logic [ID_BITS-1:0]   e_id;
  logic [TIME_BITS-1:0] e_exp;
  logic                 e_last;

  logic                 ov_q;
  status_e              ost_q;
  logic [ID_W-1:0]      oid_q;
  logic [EXP_W-1:0]     oexp_q;
  logic                 olast_q;

  assign idx_inc = idx_q + CNT_W'(1);
  assign idx_dec = idx_q - CNT_W'(1);
  assign cnt_inc = cnt_q + CNT_W'(1);
  assign cnt_dec = cnt_q - CNT_W'(1);

  assign rd_exp = mem_rdata[ENT_W-1:ID_BITS];
  assign rd_id  = mem_rdata[ID_BITS-1:0];

  stq_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (ENT_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  stq_cmp #(
    .TIME_BITS (TIME_BITS),
    .ID_BITS   (ID_BITS)
  ) u_cmp (
    .ent_exp_i  (rd_exp),
    .ent_id_i   (rd_id),
    .key_time_i (key_q),
    .key_id_i   (id_q),
    .res_o      (cmp)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_beat    = in_i.valid && in_i.ready;
  assign slot_free  = !ov_q || out_o.ready;

  // state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      cnt_q   <= '0;
      nres_q  <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      nres_q  <= nres_d;
      pend_q  <= pend_d;
    end
  end

  // command capture and held expired entry
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      op_q <= opcode_e'(in_i.opcode);
      id_q <= ID_BITS'(in_i.timer_id);
      if (opcode_e'(in_i.opcode) == OP_TICK) begin
        key_q <= TIME_BITS'(in_i.now_time);
      end else begin
        key_q <= TIME_BITS'(in_i.expire_time);
      end
    end
    hold_id_q  <= hold_id_d;
    hold_exp_q <= hold_exp_d;
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    nres_d     = nres_q;
    pend_d     = pend_q;
    hold_id_d  = hold_id_q;
    hold_exp_d = hold_exp_q;
    mem_we     = 1'b0;
    mem_waddr  = idx_q[IDX_W-1:0];
    mem_wdata  = {key_q, id_q};
    mem_raddr  = idx_q[IDX_W-1:0];
    emit       = 1'b0;
    e_status   = STS_OK;
    e_id       = id_q;
    e_exp      = '0;
    e_last     = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          idx_d  = '0;
          nres_d = '0;
          pend_d = 1'b0;
          if (opcode_e'(in_i.opcode) == OP_TICK) begin
            state_d = ST_TICK_RD;
          end else begin
            state_d = ST_FIND_RD;
          end
        end
      end

      // lookup scan from the head
      ST_FIND_RD: begin
        if (idx_q == cnt_q) begin
          if (op_q == OP_ADD) begin
            if (cnt_q == CNT_W'(CAPACITY)) begin
              e_status = STS_FULL;
              if (slot_free) begin
                emit    = 1'b1;
                state_d = ST_IDLE;
              end
            end else begin
              idx_d   = cnt_q;
              state_d = ST_INS_RD;
            end
          end else begin
            e_status = STS_NOT_FOUND;
            if (slot_free) begin
              emit    = 1'b1;
              state_d = ST_IDLE;
            end
          end
        end else begin
          state_d = ST_FIND_CMP;
        end
      end

      ST_FIND_CMP: begin
        if (cmp.hit) begin
          if (op_q == OP_ADD) begin
            e_status = STS_DUPLICATE;
            if (slot_free) begin
              emit    = 1'b1;
              state_d = ST_IDLE;
            end
          end else begin
            state_d = ST_RM_RD;
          end
        end else begin
          idx_d   = idx_inc;
          state_d = ST_FIND_RD;
        end
      end

      // removal: pull the tail down one slot
      ST_RM_RD: begin
        mem_raddr = idx_inc[IDX_W-1:0];
        if (idx_inc < cnt_q) begin
          state_d = ST_RM_WR;
        end else begin
          unique case (op_q)
            OP_ADJUST: begin
              cnt_d   = cnt_dec;
              idx_d   = cnt_dec;
              state_d = ST_INS_RD;
            end
            OP_DELETE: begin
              e_status = STS_OK;
              if (slot_free) begin
                emit    = 1'b1;
                cnt_d   = cnt_dec;
                state_d = ST_IDLE;
              end
            end
            default: begin
              cnt_d   = cnt_dec;
              state_d = ST_TICK_RD;
            end
          endcase
        end
      end

      ST_RM_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        idx_d     = idx_inc;
        state_d   = ST_RM_RD;
      end

      // insertion: walk up from the tail past every later expiry
      ST_INS_RD: begin
        mem_raddr = idx_dec[IDX_W-1:0];
        if (idx_q == '0) begin
          e_status = STS_OK;
          if (slot_free) begin
            emit    = 1'b1;
            mem_we  = 1'b1;
            cnt_d   = cnt_inc;
            state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_INS_CMP;
        end
      end

      ST_INS_CMP: begin
        mem_raddr = idx_dec[IDX_W-1:0];
        if (!cmp.due) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata;
          idx_d     = idx_dec;
          state_d   = ST_INS_RD;
        end else begin
          e_status = STS_OK;
          if (slot_free) begin
            emit    = 1'b1;
            mem_we  = 1'b1;
            cnt_d   = cnt_inc;
            state_d = ST_IDLE;
          end
        end
      end

      // tick: look at the head, retire it while due and under the result limit
      ST_TICK_RD: begin
        mem_raddr = '0;
        if (cnt_q == '0 || nres_q == NRES_W'(MAX_RESULTS)) begin
          if (pend_q) begin
            e_status = STS_EXPIRED;
            e_id     = hold_id_q;
            e_exp    = hold_exp_q;
          end else begin
            e_status = STS_NOTHING_DUE;
            e_id     = '0;
          end
          if (slot_free) begin
            emit    = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_TICK_CMP;
        end
      end

      ST_TICK_CMP: begin
        mem_raddr = '0;
        if (pend_q) begin
          e_status = STS_EXPIRED;
          e_id     = hold_id_q;
          e_exp    = hold_exp_q;
        end else begin
          e_status = STS_NOTHING_DUE;
          e_id     = '0;
        end
        if (cmp.due) begin
          e_last = 1'b0;
          if (slot_free) begin
            emit       = pend_q;
            hold_id_d  = rd_id;
            hold_exp_d = rd_exp;
            pend_d     = 1'b1;
            nres_d     = nres_q + NRES_W'(1);
            idx_d      = '0;
            state_d    = ST_RM_RD;
          end
        end else if (slot_free) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (emit) begin
      ov_q <= 1'b1;
    end else if (out_o.ready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      ost_q   <= e_status;
      oid_q   <= ID_W'(e_id);
      oexp_q  <= EXP_W'(e_exp);
      olast_q <= e_last;
    end
  end

  assign out_o.valid           = ov_q;
  assign out_o.status          = ost_q;
  assign out_o.out_timer_id    = oid_q;
  assign out_o.out_expire_time = oexp_q;
  assign out_o.last            = olast_q;

  // queue never holds more than its capacity
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("queue count above capacity");

  // one item changes the count by at most one entry per step
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |->
      (cnt_q == $past(cnt_q) + CNT_W'(1) || cnt_q == $past(cnt_q) - CNT_W'(1)))
    else $error("queue count jumped");

  // writes land inside the store
  a_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (idx_q < CNT_W'(CAPACITY)))
    else $error("entry write beyond capacity");

  // a tick never retires more than the result limit
  a_nres_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nres_q <= NRES_W'(MAX_RESULTS))
    else $error("tick retired too many timers");

endmodule

// File: sim/sorted_timer_queue_tb.sv
// testbench of the sorted timer queue: table-driven and random commands checked against a queue model
module sorted_timer_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import stq_pkg::*;

  localparam int unsigned CAPACITY     = 16;
  localparam int unsigned RAND_CMDS    = 250;
  localparam int unsigned SETTLE_EVERY = 60;
  localparam int unsigned DRAIN_CYCLES = 100;

  // one command beat, with an optional hand-typed single result
  typedef struct {
    opcode_e          op;
    logic [ID_W-1:0]  id;
    logic [EXP_W-1:0] expiry;
    logic [EXP_W-1:0] now;
    bit               fixed;
    status_e          want_sts;
    logic [ID_W-1:0]  want_id;
  } cmd_t;

  // one result beat
  typedef struct {
    status_e          sts;
    logic [ID_W-1:0]  id;
    logic [EXP_W-1:0] expiry;
    logic             last;
  } timer_evt_t;

  logic clk_i;
  logic rst_ni;

  stq_in_if  cmd_if ();
  stq_out_if evt_if ();

  sorted_timer_queue #(
    .CAPACITY  (CAPACITY),
    .TIME_BITS (EXP_W),
    .ID_BITS   (ID_W)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cmd_if),
    .out_o  (evt_if)
  );

  // queue model state
  logic [EXP_W-1:0] tq_expiry [CAPACITY];
  logic [ID_W-1:0]  tq_handle [CAPACITY];
  int               tq_count = 0;

  timer_evt_t       pending_evts [$];
  cmd_t             plan_q [$];
  int unsigned      err_cnt    = 0;
  int unsigned      burst_left = 0;
  logic [EXP_W-1:0] clock_base = 32'd1000;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop
  initial begin
    #10ms;
    $display("sorted_timer_queue_tb: done, errors");
    $finish;
  end

  function automatic timer_evt_t mk_evt(status_e s, logic [ID_W-1:0] id,
                                        logic [EXP_W-1:0] t, logic last);
    timer_evt_t e;
    e.sts    = s;
    e.id     = id;
    e.expiry = t;
    e.last   = last;
    return e;
  endfunction

  function automatic int find_handle(logic [ID_W-1:0] id);
    for (int i = 0; i < tq_count; i++) begin
      if (tq_handle[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic void drop_at(int pos);
    for (int i = pos; i + 1 < tq_count; i++) begin
      tq_expiry[i] = tq_expiry[i+1];
      tq_handle[i] = tq_handle[i+1];
    end
    tq_count--;
  endfunction

  // new timer goes after every timer of equal or earlier expiry
  function automatic void place_sorted(logic [ID_W-1:0] id, logic [EXP_W-1:0] t);
    int pos;
    pos = 0;
    while (pos < tq_count && tq_expiry[pos] <= t) pos++;
    for (int i = tq_count; i > pos; i--) begin
      tq_expiry[i] = tq_expiry[i-1];
      tq_handle[i] = tq_handle[i-1];
    end
    tq_expiry[pos] = t;
    tq_handle[pos] = id;
    tq_count++;
  endfunction

  // apply one command to the queue model and give the result beats it causes
  function automatic void apply_to_queue(cmd_t c, ref timer_evt_t evts[$]);
    int pos;
    int n;
    evts.delete();
    case (c.op)
      OP_ADD: begin
        if (find_handle(c.id) >= 0) begin
          evts.push_back(mk_evt(STS_DUPLICATE, c.id, '0, 1'b1));
        end else if (tq_count >= CAPACITY) begin
          evts.push_back(mk_evt(STS_FULL, c.id, '0, 1'b1));
        end else begin
          place_sorted(c.id, c.expiry);
          evts.push_back(mk_evt(STS_OK, c.id, '0, 1'b1));
        end
      end
      OP_ADJUST, OP_DELETE: begin
        pos = find_handle(c.id);
        if (pos < 0) begin
          evts.push_back(mk_evt(STS_NOT_FOUND, c.id, '0, 1'b1));
        end else begin
          drop_at(pos);
          if (c.op == OP_ADJUST) place_sorted(c.id, c.expiry);
          evts.push_back(mk_evt(STS_OK, c.id, '0, 1'b1));
        end
      end
      default: begin
        // tick: pop due timers from the head
        n = 0;
        while (n < MAX_RESULTS && tq_count > 0 && tq_expiry[0] <= c.now) begin
          evts.push_back(mk_evt(STS_EXPIRED, tq_handle[0], tq_expiry[0], 1'b0));
          drop_at(0);
          n++;
        end
        if (n == 0) evts.push_back(mk_evt(STS_NOTHING_DUE, '0, '0, 1'b1));
        else evts[n-1].last = 1'b1;
      end
    endcase
  endfunction

  function automatic void plan_row(opcode_e op, int id, logic [EXP_W-1:0] expiry,
                                   logic [EXP_W-1:0] now, bit fixed, status_e sts,
                                   int wid);
    cmd_t c;
    c.op       = op;
    c.id       = ID_W'(id);
    c.expiry   = expiry;
    c.now      = now;
    c.fixed    = fixed;
    c.want_sts = sts;
    c.want_id  = ID_W'(wid);
    plan_q.push_back(c);
  endfunction

  // random command: ids mostly from a small pool so that hits, duplicates and a
  // full queue are common, times mostly near a slowly advancing clock
  function automatic cmd_t rand_cmd();
    cmd_t        c;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) c.op = OP_ADD;
    else if (pick < 55) c.op = OP_ADJUST;
    else if (pick < 70) c.op = OP_DELETE;
    else c.op = OP_TICK;

    if ((c.op == OP_ADJUST || c.op == OP_DELETE) && tq_count > 0 &&
        $urandom_range(0, 2) != 0) begin
      c.id = tq_handle[$urandom_range(0, tq_count - 1)];
    end else if ($urandom_range(0, 4) != 0) begin
      c.id = ID_W'($urandom_range(0, 23));
    end else begin
      c.id = ID_W'($urandom());
    end

    if ($urandom_range(0, 7) != 0) c.expiry = clock_base + $urandom_range(0, 40);
    else c.expiry = $urandom();

    if (c.op == OP_TICK) begin
      pick = $urandom_range(0, 9);
      if (pick < 8) c.now = clock_base + $urandom_range(0, 30);
      else if (pick == 8) c.now = $urandom();
      else c.now = '1;
      clock_base = clock_base + $urandom_range(0, 20);
    end else begin
      c.now = $urandom();
    end

    c.fixed    = 1'b0;
    c.want_sts = STS_OK;
    c.want_id  = '0;
    return c;
  endfunction

  // drive one command and wait for its beat; valid stays high afterwards
  task automatic push_cmd(cmd_t c);
    timer_evt_t evts [$];
    cmd_if.valid       <= 1'b1;
    cmd_if.opcode      <= c.op;
    cmd_if.timer_id    <= c.id;
    cmd_if.expire_time <= c.expiry;
    cmd_if.now_time    <= c.now;
    do @(posedge clk_i); while (!cmd_if.ready);
    apply_to_queue(c, evts);
    if (c.fixed) pending_evts.push_back(mk_evt(c.want_sts, c.want_id, '0, 1'b1));
    else foreach (evts[i]) pending_evts.push_back(evts[i]);
  endtask

  // sender bursts with random gaps
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 6);
      if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(20, 40);
      else burst_left = $urandom_range(0, 8);
      if (gap != 0) begin
        cmd_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // hold off until every expected beat has come back
  task automatic settle_queue();
    cmd_if.valid <= 1'b0;
    while (pending_evts.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // stimulus
  initial begin
    rst_ni             <= 1'b0;
    cmd_if.valid       <= 1'b0;
    cmd_if.opcode      <= OP_ADD;
    cmd_if.timer_id    <= '0;
    cmd_if.expire_time <= '0;
    cmd_if.now_time    <= '0;

    // empty queue, not found, duplicate, extremes
    plan_row(OP_TICK,   0,   '0,      '0,    1, STS_NOTHING_DUE, 0);
    plan_row(OP_ADJUST, 255, '1,      '0,    1, STS_NOT_FOUND,   255);
    plan_row(OP_DELETE, 0,   '0,      '1,    1, STS_NOT_FOUND,   0);
    plan_row(OP_ADD,    255, '1,      '1,    1, STS_OK,          255);
    plan_row(OP_ADD,    255, 32'd5,   '0,    1, STS_DUPLICATE,   255);
    plan_row(OP_ADD,    0,   '0,      '0,    1, STS_OK,          0);
    // later adjust, equal expiries, earlier adjust onto a tie
    plan_row(OP_ADJUST, 0,   32'd100, '0,    0, STS_OK,          0);
    plan_row(OP_ADD,    1,   32'd100, '0,    0, STS_OK,          0);
    plan_row(OP_ADJUST, 255, 32'd100, '0,    0, STS_OK,          0);
    // tail delete, then a tick just short of the head
    plan_row(OP_DELETE, 255, '0,      '0,    1, STS_OK,          255);
    plan_row(OP_TICK,   255, '1,      32'd99, 1, STS_NOTHING_DUE, 0);
    // fill to capacity, overflow, then flush all sixteen in one tick
    for (int i = 2; i < CAPACITY; i++) begin
      plan_row(OP_ADD, i, 32'(100 - (i % 4) * 30), '0, 0, STS_OK, 0);
    end
    plan_row(OP_ADD,  200, 32'd5, '0, 1, STS_FULL, 200);
    plan_row(OP_TICK, 0,   '0,    '1, 0, STS_OK,   0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan_q[i]) begin
      push_cmd(plan_q[i]);
      pace_sender();
    end
    settle_queue();

    for (int k = 0; k < RAND_CMDS; k++) begin
      push_cmd(rand_cmd());
      if (k % SETTLE_EVERY == SETTLE_EVERY - 1 || k == RAND_CMDS - 1) settle_queue();
      else pace_sender();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("sorted_timer_queue_tb: done, clean");
    end else begin
      $display("sorted_timer_queue_tb: done, errors");
    end
    $finish;
  end

  // receiver stall pattern: phases of always ready, coin flips, and runs
  initial begin
    int unsigned phase_left;
    int unsigned mode;
    int unsigned hold;
    logic        run_rdy;
    phase_left = 0;
    mode       = 0;
    hold       = 0;
    run_rdy    = 1'b1;
    evt_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (phase_left == 0) begin
        mode       = $urandom_range(0, 2);
        phase_left = $urandom_range(20, 120);
      end
      phase_left--;
      case (mode)
        0: evt_if.ready <= 1'b1;
        1: evt_if.ready <= ($urandom_range(0, 1) == 1);
        default: begin
          if (hold == 0) begin
            run_rdy = ~run_rdy;
            hold    = $urandom_range(1, 8);
          end
          hold--;
          evt_if.ready <= run_rdy;
        end
      endcase
    end
  end

  // result checker
  always @(posedge clk_i) begin
    timer_evt_t want;
    if (rst_ni && evt_if.valid && evt_if.ready) begin
      if (pending_evts.size() == 0) begin
        $error("unexpected result beat: status %0d id %0d", evt_if.status,
               evt_if.out_timer_id);
        err_cnt++;
      end else begin
        want = pending_evts.pop_front();
        if (evt_if.status !== want.sts) begin
          $error("status: expected %0d, got %0d", want.sts, evt_if.status);
          err_cnt++;
        end
        if (evt_if.out_timer_id !== want.id) begin
          $error("out_timer_id: expected %0d, got %0d", want.id, evt_if.out_timer_id);
          err_cnt++;
        end
        if (evt_if.out_expire_time !== want.expiry) begin
          $error("out_expire_time: expected %0d, got %0d", want.expiry,
                 evt_if.out_expire_time);
          err_cnt++;
        end
        if (evt_if.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, evt_if.last);
          err_cnt++;
        end
      end
    end
  end

endmodule
